[rtl/gsbtb_pkg.sv]
// Shared types and constants for the gshare predictor with BTB.
// No dependencies; imported by the lookup, core and checker files and by the bench.
`default_nettype none

package gsbtb_pkg;

    localparam int unsigned PC_W  = 32;
    localparam int unsigned CNT_W = 2;

    // Fall-through step of a sequential fetch.
    localparam logic [PC_W-1:0] FETCH_STEP = 32'd4;

    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt CNT_MIN = 2'd0;
    localparam t_cnt CNT_MAX = 2'd3;

    typedef enum logic {
        KIND_PREDICT = 1'b0,
        KIND_UPDATE  = 1'b1
    } t_kind;

    // Request item: a lookup or a resolved branch.
    typedef struct packed {
        t_kind           kind;
        logic [PC_W-1:0] pc;
        logic            taken;
        logic            is_conditional;
        logic [PC_W-1:0] target;
    } t_req;

    // Result item.
    typedef struct packed {
        logic            predicted_taken;
        logic [PC_W-1:0] predicted_target;
    } t_rsp;

    // One BTB line; tag is the whole pc.
    typedef struct packed {
        logic            valid;
        logic            uncond;
        logic [PC_W-1:0] tag;
        logic [PC_W-1:0] target;
    } t_btb_entry;

    localparam int unsigned BTB_ENTRY_W = $bits(t_btb_entry);

    // Write-back controls produced by the resolve logic.
    typedef struct packed {
        logic       btb_we;
        logic       pht_we;
        t_btb_entry btb_entry;
        t_cnt       cnt;
    } t_wr_ctl;

endpackage

`default_nettype wire

[rtl/gsbtb_chan_if.sv]
// Valid/ready channel carrying one payload item per handshake.
// Payload type is a parameter; used with gsbtb_pkg::t_req and t_rsp.
`default_nettype none

interface gsbtb_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/gsbtb_ram.sv]
// Single-write, single-read RAM with registered read and write-first bypass.
// No package dependency; used for the BTB and the counter table.
`default_nettype none

module gsbtb_ram #(
    parameter int unsigned ADDR_W = 10,
    parameter int unsigned DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    output      logic [DATA_W-1:0] o_rd_data
);

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // same-edge write to the read address wins
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/gsbtb_lookup.sv]
// Prediction decision and resolve write-back for the item held in stage 1.
// Depends on gsbtb_pkg.
`default_nettype none

module gsbtb_lookup (
    input  wire gsbtb_pkg::t_req       i_item,
    input  wire gsbtb_pkg::t_btb_entry i_entry,
    input  wire gsbtb_pkg::t_cnt       i_cnt,
    output      gsbtb_pkg::t_rsp       o_rsp,
    output      gsbtb_pkg::t_wr_ctl    o_wr
);
    import gsbtb_pkg::*;

    logic hit;
    t_cnt cnt_next;

    assign hit = i_entry.valid && (i_entry.tag == i_item.pc);

    // saturating 2-bit counter
    always_comb begin
        cnt_next = i_cnt;
        if (i_item.taken) begin
            if (i_cnt != CNT_MAX) begin
                cnt_next = i_cnt + t_cnt'(1);
            end
        end else begin
            if (i_cnt != CNT_MIN) begin
                cnt_next = i_cnt - t_cnt'(1);
            end
        end
    end

    always_comb begin
        o_rsp = '0;
        o_wr  = '0;
        unique case (i_item.kind)
            KIND_PREDICT: begin
                if (hit && (i_entry.uncond || i_cnt[CNT_W-1])) begin
                    o_rsp.predicted_taken  = 1'b1;
                    o_rsp.predicted_target = i_entry.target;
                end else begin
                    o_rsp.predicted_taken  = 1'b0;
                    o_rsp.predicted_target = i_item.pc + FETCH_STEP;
                end
            end
            KIND_UPDATE: begin
                o_wr.btb_we           = 1'b1;
                o_wr.btb_entry.valid  = 1'b1;
                o_wr.btb_entry.uncond = !i_item.is_conditional;
                o_wr.btb_entry.tag    = i_item.pc;
                o_wr.btb_entry.target = i_item.target;
                o_wr.pht_we           = i_item.is_conditional;
                o_wr.cnt              = cnt_next;
            end
            default: begin
                o_rsp = '0;
                o_wr  = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/gshare_predictor_with_btb_core.sv]
// An accepted item passes through stage 1 (RAM reads) and then the output register.
// Throughput: one item per cycle unless o_rsp.ready stalls the output; set by the
// one-write-one-read BTB and counter RAMs. Reset: history and handshake state clear at
// once; a clearing sweep over every BTB and counter address then zeroes both RAMs
// with i_req.ready low. BTB_ENTRIES must be a power of two.
`default_nettype none

module gshare_predictor_with_btb_core #(
    parameter int unsigned BTB_ENTRIES  = 1024,
    parameter int unsigned HISTORY_BITS = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gsbtb_chan_if.sink   i_req,
    gsbtb_chan_if.source o_rsp
);
    import gsbtb_pkg::*;

    localparam int unsigned BTB_IDX_W = $clog2(BTB_ENTRIES);
    localparam int unsigned PHT_IDX_W = HISTORY_BITS;
    localparam int unsigned CLR_W     = (BTB_IDX_W > PHT_IDX_W) ? BTB_IDX_W : PHT_IDX_W;

    localparam logic [CLR_W-1:0] CLR_LAST = '1;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic                    r_clr_busy;
    logic [CLR_W-1:0]        r_clr_idx;
    logic [HISTORY_BITS-1:0] r_hist;
    logic [HISTORY_BITS-1:0] n_hist;

    // stage 1: item whose RAM reads are in flight
    logic                    r_s1_valid;
    t_req                    r_s1_item;
    logic [PHT_IDX_W-1:0]    r_s1_pht_idx;

    // output register
    logic                    r_out_valid;
    t_rsp                    r_out_rsp;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic s1_adv;
    logic in_ready;
    logic in_acc;

    // stage 1 leaves when the output register is free or being drained
    assign s1_adv   = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_acc   = i_req.valid && in_ready;

    assign i_req.ready = in_ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_rsp;

    // ---------------------------------------------------------------
    // Decision logic for the stage-1 item
    // ---------------------------------------------------------------
    t_btb_entry btb_rd_entry;
    t_cnt       pht_rd_cnt;
    t_rsp       s1_rsp;
    t_wr_ctl    s1_wr;

    gsbtb_lookup u_lookup (
        .i_item  (r_s1_item),
        .i_entry (btb_rd_entry),
        .i_cnt   (pht_rd_cnt),
        .o_rsp   (s1_rsp),
        .o_wr    (s1_wr)
    );

    // History moves when a conditional resolve retires. The next item's
    // counter index is formed from the post-shift value so that a
    // back-to-back lookup sees the same history it would serially.
    always_comb begin
        n_hist = r_hist;
        if (s1_adv && s1_wr.pht_we) begin
            n_hist = {r_hist[HISTORY_BITS-2:0], r_s1_item.taken};
        end
    end

    // ---------------------------------------------------------------
    // RAM ports
    // ---------------------------------------------------------------
    logic [BTB_IDX_W-1:0] btb_rd_idx;
    logic [PHT_IDX_W-1:0] pht_rd_idx;
    logic                 btb_we;
    logic [BTB_IDX_W-1:0] btb_wr_idx;
    t_btb_entry           btb_wr_entry;
    logic                 pht_we;
    logic [PHT_IDX_W-1:0] pht_wr_idx;
    t_cnt                 pht_wr_cnt;

    assign btb_rd_idx = i_req.data.pc[BTB_IDX_W+1:2];
    assign pht_rd_idx = n_hist ^ i_req.data.pc[PHT_IDX_W+1:2];

    // the clearing sweep owns the write ports until it finishes
    always_comb begin
        if (r_clr_busy) begin
            btb_we       = 1'b1;
            btb_wr_idx   = r_clr_idx[BTB_IDX_W-1:0];
            btb_wr_entry = '0;
            pht_we       = 1'b1;
            pht_wr_idx   = r_clr_idx[PHT_IDX_W-1:0];
            pht_wr_cnt   = CNT_MIN;
        end else begin
            btb_we       = s1_adv && s1_wr.btb_we;
            btb_wr_idx   = r_s1_item.pc[BTB_IDX_W+1:2];
            btb_wr_entry = s1_wr.btb_entry;
            pht_we       = s1_adv && s1_wr.pht_we;
            pht_wr_idx   = r_s1_pht_idx;
            pht_wr_cnt   = s1_wr.cnt;
        end
    end

    gsbtb_ram #(
        .ADDR_W (BTB_IDX_W),
        .DATA_W (BTB_ENTRY_W)
    ) u_btb (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (btb_rd_idx),
        .i_wr_en   (btb_we),
        .i_wr_addr (btb_wr_idx),
        .i_wr_data (btb_wr_entry),
        .o_rd_data (btb_rd_entry)
    );

    gsbtb_ram #(
        .ADDR_W (PHT_IDX_W),
        .DATA_W (CNT_W)
    ) u_pht (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (pht_rd_idx),
        .i_wr_en   (pht_we),
        .i_wr_addr (pht_wr_idx),
        .i_wr_data (pht_wr_cnt),
        .o_rd_data (pht_rd_cnt)
    );

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_hist      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + CLR_W'(1);
                if (r_clr_idx == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end

            r_hist <= n_hist;

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item    <= i_req.data;
            r_s1_pht_idx <= pht_rd_idx;
        end
        if (s1_adv) begin
            r_out_rsp <= s1_rsp;
        end
    end

endmodule

`default_nettype wire

[rtl/gsbtb_chk.sv]
// Port-level checker for gshare_predictor_with_btb_core, bound to the top level.
// Depends on gsbtb_pkg; tracks in-flight items from the request handshake.
`default_nettype none

module gsbtb_chk (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire gsbtb_pkg::t_req   i_req_data,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire gsbtb_pkg::t_rsp   i_rsp_data
);
    import gsbtb_pkg::*;

    localparam logic [2:0] MAX_INFLIGHT = 3'd2;

    logic            req_acc;
    logic            rsp_acc;
    t_kind           r_kind [4];
    logic [PC_W-1:0] r_pc   [4];
    logic [1:0]      r_wp;
    logic [1:0]      r_rp;
    logic [2:0]      r_pending;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_pending <= '0;
        end else begin
            if (req_acc) begin
                r_wp <= r_wp + 2'd1;
            end
            if (rsp_acc) begin
                r_rp <= r_rp + 2'd1;
            end
            r_pending <= r_pending + {2'b00, req_acc} - {2'b00, rsp_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_kind[r_wp] <= i_req_data.kind;
            r_pc[r_wp]   <= i_req_data.pc;
        end
    end

    // reset blocks both sides until the sweep is under way
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && !i_req_ready)
        else $error("handshake active straight after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled result changed");

    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending <= MAX_INFLIGHT) && (!i_rsp_valid || (r_pending != 3'd0)))
        else $error("result without item or too many items in flight");

    a_update_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_acc && (r_kind[r_rp] == KIND_UPDATE) |-> i_rsp_data == '0)
        else $error("update item gave a non-zero result");

    a_fall_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_acc && (r_kind[r_rp] == KIND_PREDICT) && !i_rsp_data.predicted_taken
        |-> i_rsp_data.predicted_target == r_pc[r_rp] + FETCH_STEP)
        else $error("not-taken prediction without pc+4 target");

endmodule

bind gshare_predictor_with_btb_core gsbtb_chk u_gsbtb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_data  (i_req.data),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for gshare_predictor_with_btb_core: predicts each result from its own
// copy of history, counters and BTB. Depends on rtl/gsbtb_pkg.sv and rtl/gsbtb_chan_if.sv.

module tb;
    import gsbtb_pkg::*;

    localparam int unsigned BTB_SLOTS = 1024;
    localparam int unsigned BTB_IDX_W = $clog2(BTB_SLOTS);
    localparam int unsigned GHR_W     = 8;
    localparam int unsigned N_RANDOM  = 1100;
    localparam int unsigned POOL_SIZE = 24;
    // Covers the clearing sweep after reset with plenty to spare.
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n;

    gsbtb_chan_if #(.T(t_req)) req_if ();
    gsbtb_chan_if #(.T(t_rsp)) rsp_if ();

    gshare_predictor_with_btb_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Local copy of the predictor state
    // ---------------------------------------------------------------------
    logic [GHR_W-1:0] ghr;
    t_cnt             pht [2**GHR_W];
    logic             btb_ok   [BTB_SLOTS];
    logic             btb_jump [BTB_SLOTS];
    logic [PC_W-1:0]  btb_tag  [BTB_SLOTS];
    logic [PC_W-1:0]  btb_dest [BTB_SLOTS];

    t_req branch_q [$];     // items still to be offered
    t_rsp next_fetch_q [$]; // predicted results, oldest first

    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int idle_cycles = 0;

    // Works out the result of one item and advances the local state.
    function automatic t_rsp gshare_step(input t_req r);
        logic [BTB_IDX_W-1:0] bi;
        logic [GHR_W-1:0]     pi;
        t_rsp                 res;
        bi  = r.pc[BTB_IDX_W+1:2];
        // Counter index uses history from before any shift.
        pi  = ghr ^ r.pc[GHR_W+1:2];
        res = '0;
        if (r.kind == KIND_PREDICT) begin
            // Counter top bit set means weakly or strongly taken.
            if (btb_ok[bi] && btb_tag[bi] == r.pc && (btb_jump[bi] || pht[pi][1])) begin
                res.predicted_taken  = 1'b1;
                res.predicted_target = btb_dest[bi];
            end else begin
                res.predicted_target = r.pc + FETCH_STEP; // wraps at 32 bits
            end
        end else begin
            if (r.is_conditional) begin
                if (r.taken && pht[pi] != CNT_MAX)
                    pht[pi] = pht[pi] + 1'b1;
                else if (!r.taken && pht[pi] != CNT_MIN)
                    pht[pi] = pht[pi] - 1'b1;
                ghr = {ghr[GHR_W-2:0], r.taken};
            end
            // Jumps leave history and counters alone but still fill the BTB.
            btb_ok[bi]   = 1'b1;
            btb_tag[bi]  = r.pc;
            btb_jump[bi] = !r.is_conditional;
            btb_dest[bi] = r.target;
        end
        return res;
    endfunction

    function automatic t_req mk_branch(input t_kind k, input logic [PC_W-1:0] pc,
                                       input logic tk, input logic cond,
                                       input logic [PC_W-1:0] dest);
        t_req r;
        r.kind           = k;
        r.pc             = pc;
        r.taken          = tk;
        r.is_conditional = cond;
        r.target         = dest;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: offers items from branch_q, predicts each one as it is taken
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                next_fetch_q.push_back(gshare_step(req_if.data));
                n_accepted++;
            end
            // Slot is free once the current item has gone (or none was offered).
            if (!req_if.valid || req_if.ready) begin
                if (branch_q.size() > 0 &&
                    ((n_accepted >= 600 && n_accepted < 800) || $urandom_range(99) >= 12)) begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= branch_q.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver back-pressure: random stalls, one long hold-off, a calm stretch
    // ---------------------------------------------------------------------
    int  hold_left = 0;
    bit  held_once = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (!held_once && n_results >= 500) begin
            // Sender keeps offering meanwhile, so the core fills and stalls i_req.
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= (n_results >= 650 && n_results < 850) || $urandom_range(99) >= 12;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: compare each result with the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            n_results++;
            if (next_fetch_q.size() == 0) begin
                $error("result with nothing outstanding: taken %0d, target %h",
                       rsp_if.data.predicted_taken, rsp_if.data.predicted_target);
                n_errors++;
            end else begin
                want = next_fetch_q.pop_front();
                if (rsp_if.data.predicted_taken !== want.predicted_taken) begin
                    $error("predicted_taken: expected %0d, got %0d",
                           want.predicted_taken, rsp_if.data.predicted_taken);
                    n_errors++;
                end
                if (rsp_if.data.predicted_target !== want.predicted_target) begin
                    $error("predicted_target: expected %h, got %h",
                           want.predicted_target, rsp_if.data.predicted_target);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake on either side.
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    logic [PC_W-1:0] pool      [POOL_SIZE];
    logic            pool_bias [POOL_SIZE];

    initial begin
        int               pick;
        int               mode;
        logic [PC_W-1:0]  pc;
        logic             cond;
        logic             tk;

        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        ghr          = '0;
        foreach (pht[i]) pht[i] = CNT_MIN;
        foreach (btb_ok[i]) begin
            btb_ok[i]   = 1'b0;
            btb_jump[i] = 1'b0;
            btb_tag[i]  = '0;
            btb_dest[i] = '0;
        end

        // Directed: extremes of pc and target, jumps, saturation, tag alias.
        branch_q.push_back(mk_branch(KIND_PREDICT, 32'h0000_0000, 1'b0, 1'b0, '0));
        branch_q.push_back(mk_branch(KIND_PREDICT, 32'hFFFF_FFFC, 1'b0, 1'b0, '0)); // pc+4 wraps
        branch_q.push_back(mk_branch(KIND_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, '1));
        // Jump with taken low: taken is ignored, entry becomes unconditional.
        branch_q.push_back(mk_branch(KIND_UPDATE, 32'h0000_0100, 1'b0, 1'b0, 32'h0000_2000));
        branch_q.push_back(mk_branch(KIND_PREDICT, 32'h0000_0100, 1'b0, 1'b0, '0));
        // Fields that only matter on updates must not affect a lookup.
        branch_q.push_back(mk_branch(KIND_PREDICT, 32'h0000_0100, 1'b1, 1'b1, 32'hFFFF_FFFF));
        // Same BTB slot, different tag: a miss.
        branch_q.push_back(mk_branch(KIND_PREDICT, 32'h0000_1100, 1'b0, 1'b0, '0));
        // Train a conditional branch until history is all ones and the counter saturates.
        repeat (11)
            branch_q.push_back(mk_branch(KIND_UPDATE, 32'h0000_0200, 1'b1, 1'b1,
                                         32'h0000_0300));
        branch_q.push_back(mk_branch(KIND_PREDICT, 32'h0000_0200, 1'b0, 1'b0, '0));
        // Four not-taken resolves shift zeros into history, each on a different counter.
        repeat (4)
            branch_q.push_back(mk_branch(KIND_UPDATE, 32'h0000_0200, 1'b0, 1'b1,
                                         32'h0000_0300));
        branch_q.push_back(mk_branch(KIND_PREDICT, 32'h0000_0200, 1'b0, 1'b0, '0));
        branch_q.push_back(mk_branch(KIND_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF));
        branch_q.push_back(mk_branch(KIND_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b0, '0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Sender pauses here until every directed result is back.
        while (branch_q.size() != 0 || req_if.valid || next_fetch_q.size() != 0)
            @(posedge clk);

        // Small working set of branches so lookups hit and counters train.
        foreach (pool[i]) begin
            pool[i]      = ($urandom_range(3) == 0) ? $urandom : ($urandom & 32'hFFFF_FFFC);
            pool_bias[i] = 1'($urandom_range(1));
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(POOL_SIZE - 1);
            mode = $urandom_range(99);
            pc   = (mode >= 80) ? $urandom : pool[pick];
            cond = $urandom_range(3) != 0;
            tk   = pool_bias[pick] ? ($urandom_range(99) < 85) : ($urandom_range(99) < 15);
            if (mode < 45 || (mode >= 80 && mode < 90))
                branch_q.push_back(mk_branch(KIND_PREDICT, pc, 1'($urandom_range(1)),
                                             1'($urandom_range(1)), $urandom));
            else
                branch_q.push_back(mk_branch(KIND_UPDATE, pc, tk, cond, $urandom));
        end

        while (branch_q.size() != 0 || req_if.valid || next_fetch_q.size() != 0)
            @(posedge clk);
        // A further wait catches any stray result.
        repeat (8) @(posedge clk);

        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/gsbtb_pkg.sv
rtl/gsbtb_chan_if.sv
rtl/gsbtb_ram.sv
rtl/gsbtb_lookup.sv
rtl/gshare_predictor_with_btb_core.sv
rtl/gsbtb_chk.sv
tb/tb.sv
